// ===== src/glpd_pkg.sv =====
// Package for the grid local peak detector.
// Holds configuration register codes, report kinds and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package glpd_pkg;

  // Width of a size register and of the configuration data port
  localparam int SIZE_BITS = 11;
  // Width of the row and column fields of a report
  localparam int IDX_BITS = 10;
  // Width of the configuration register index
  localparam int CFG_INDEX_BITS = 1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_COLUMNS = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_ROWS    = 1'b1;

  // Reset values of the size registers
  localparam logic [SIZE_BITS-1:0] GRID_COLUMNS_RESET = 11'd7;
  localparam logic [SIZE_BITS-1:0] GRID_ROWS_RESET    = 11'd6;

  // Smallest grid dimension; smaller register values act as this
  localparam int MIN_SIZE = 3;

  // Report kinds
  localparam logic REPORT_PEAK    = 1'b0;
  localparam logic REPORT_SUMMARY = 1'b1;

endpackage : glpd_pkg

`default_nettype wire

// ===== src/glpd_line_ram.sv =====
// One line store of the peak detector: one write port, one read port.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module glpd_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : glpd_line_ram

`default_nettype wire

// ===== src/glpd_cell.sv =====
// Window cell of the peak detector: holds one neighbor sample and tests the
// center against it. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module glpd_cell #(
  parameter int WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    advance,
  input  logic signed [WIDTH-1:0] d,
  input  logic signed [WIDTH-1:0] center,
  output logic signed [WIDTH-1:0] q,
  output logic                    center_gt
);

  // shift in the neighbor value once per transaction
  always_ff @(posedge clk) begin
    if (advance) begin
      q <= d;
    end
  end

  assign center_gt = center > q;

endmodule : glpd_cell

`default_nettype wire

// ===== src/glpd_window.sv =====
// Neighborhood window of the peak detector: center register, left and upper
// cells, and the right and lower compares. Depends on glpd_cell.
`timescale 1ns / 1ps
`default_nettype none

module glpd_window #(
  parameter int WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    advance,
  input  logic signed [WIDTH-1:0] right,
  input  logic signed [WIDTH-1:0] upper_in,
  input  logic signed [WIDTH-1:0] lower,
  output logic signed [WIDTH-1:0] center,
  output logic                    center_max
);

  logic signed [WIDTH-1:0] left_q;
  logic signed [WIDTH-1:0] upper_q;
  logic                    left_gt;
  logic                    upper_gt;

  // center takes the prefetched right neighbor, left takes the old center
  always_ff @(posedge clk) begin
    if (advance) begin
      center <= right;
    end
  end

  glpd_cell #(.WIDTH(WIDTH)) u_left_cell (
    .clk       (clk),
    .advance   (advance),
    .d         (center),
    .center    (center),
    .q         (left_q),
    .center_gt (left_gt)
  );

  glpd_cell #(.WIDTH(WIDTH)) u_upper_cell (
    .clk       (clk),
    .advance   (advance),
    .d         (upper_in),
    .center    (center),
    .q         (upper_q),
    .center_gt (upper_gt)
  );

  assign center_max = left_gt && upper_gt && (center > right) && (center > lower);

endmodule : glpd_window

`default_nettype wire

// ===== src/grid_local_peak_detector.sv =====
// Grid local peak detector, top level: config, counters, line stores, window, running maximum, result buffer.
// Throughput: one sample per cycle while in_ready is high; each result is registered by its sample's transaction.
// The rate is set by the single-port-read line stores, which are prefetched one column ahead.
// Input stalls only when both output slots are full, and in the cycle after a config write.
// Reset (synchronous, active high) clears counters, running maximum and buffer valids; config regs load 7 and 6.
// Depends on glpd_pkg, glpd_line_ram, glpd_window.
`timescale 1ns / 1ps
`default_nettype none

module grid_local_peak_detector #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [glpd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [glpd_pkg::SIZE_BITS-1:0]        cfg_data,
  // sample channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_BITS-1:0]         sample,
  // report channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  report_kind,
  output logic signed [SAMPLE_BITS-1:0]         peak_value,
  output logic [glpd_pkg::IDX_BITS-1:0]         peak_row,
  output logic [glpd_pkg::IDX_BITS-1:0]         peak_column,
  output logic                                  frame_done
);

  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CXW = (glpd_pkg::SIZE_BITS > CW + 1) ? glpd_pkg::SIZE_BITS : CW + 1;
  localparam int RXW = (glpd_pkg::SIZE_BITS > RW + 1) ? glpd_pkg::SIZE_BITS : RW + 1;

  typedef struct packed {
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] value;
    logic [glpd_pkg::IDX_BITS-1:0] row;
    logic [glpd_pkg::IDX_BITS-1:0] column;
    logic                          done;
  } report_t;

  // ---------------------------------------------------------------------
  // Configuration registers and effective grid size
  // ---------------------------------------------------------------------
  logic [glpd_pkg::SIZE_BITS-1:0] grid_columns;
  logic [glpd_pkg::SIZE_BITS-1:0] grid_rows;
  logic                           cfg_hold;
  logic [CXW-1:0]                 cols_x;
  logic [RXW-1:0]                 rows_x;
  logic [CW:0]                    cols_eff;
  logic [RW:0]                    rows_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= glpd_pkg::GRID_COLUMNS_RESET;
      grid_rows    <= glpd_pkg::GRID_ROWS_RESET;
      cfg_hold     <= 1'b0;
    end else begin
      // hold off input in the cycle after a write so the prefetch read is redone with the new size
      cfg_hold <= cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          glpd_pkg::CFG_GRID_COLUMNS: grid_columns <= cfg_data;
          glpd_pkg::CFG_GRID_ROWS:    grid_rows    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // clamp the size registers into [3, MAX]
  always_comb begin
    cols_x = CXW'(grid_columns);
    if (cols_x < CXW'(glpd_pkg::MIN_SIZE)) begin
      cols_x = CXW'(glpd_pkg::MIN_SIZE);
    end else if (cols_x > CXW'(MAX_COLUMNS)) begin
      cols_x = CXW'(MAX_COLUMNS);
    end
    cols_eff = cols_x[CW:0];

    rows_x = RXW'(grid_rows);
    if (rows_x < RXW'(glpd_pkg::MIN_SIZE)) begin
      rows_x = RXW'(glpd_pkg::MIN_SIZE);
    end else if (rows_x > RXW'(MAX_ROWS)) begin
      rows_x = RXW'(MAX_ROWS);
    end
    rows_eff = rows_x[RW:0];
  end

  // ---------------------------------------------------------------------
  // Position counters
  // ---------------------------------------------------------------------
  logic [CW-1:0] c_q;
  logic [RW-1:0] r_q;
  logic          fire;
  logic          last_col;
  logic          last_row;
  logic [CW-1:0] c_next;
  logic [CW-1:0] c_after;
  logic [CW-1:0] rd_addr;

  assign fire     = in_valid && in_ready;
  // a count at or past the last column (size shrunk mid-grid) counts as the last one
  assign last_col = ((CW + 1)'(c_q) + (CW + 1)'(1)) >= cols_eff;
  assign last_row = ((RW + 1)'(r_q) + (RW + 1)'(1)) >= rows_eff;
  assign c_next   = last_col ? '0 : c_q + CW'(1);
  assign c_after  = (((CW + 1)'(c_next) + (CW + 1)'(1)) >= cols_eff) ? '0
                                                                    : c_next + CW'(1);

  // Keep the line store outputs on the column after the current one; on a
  // transaction, move the prefetch one further so it lines up with the next sample.
  assign rd_addr = fire ? c_after : c_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_q <= '0;
      r_q <= '0;
    end else if (fire) begin
      c_q <= c_next;
      if (last_col) begin
        r_q <= last_row ? '0 : r_q + RW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Line stores: middle holds the previous row, upper the row before it
  // ---------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] middle_rd;
  logic signed [SAMPLE_BITS-1:0] upper_rd;
  logic signed [SAMPLE_BITS-1:0] center;
  logic                          center_max;

  glpd_line_ram #(.DEPTH(MAX_COLUMNS), .WIDTH(SAMPLE_BITS)) u_middle_line (
    .clk   (clk),
    .we    (fire),
    .waddr (c_q),
    .wdata (sample),
    .raddr (rd_addr),
    .rdata (middle_rd)
  );

  // the old center drops down into the upper row as the new sample replaces it
  glpd_line_ram #(.DEPTH(MAX_COLUMNS), .WIDTH(SAMPLE_BITS)) u_upper_line (
    .clk   (clk),
    .we    (fire),
    .waddr (c_q),
    .wdata (center),
    .raddr (rd_addr),
    .rdata (upper_rd)
  );

  // ---------------------------------------------------------------------
  // Window: center = middle[c], left = middle[c-1], right = middle[c+1],
  // up = upper[c], down = incoming sample
  // ---------------------------------------------------------------------
  glpd_window #(.WIDTH(SAMPLE_BITS)) u_window (
    .clk        (clk),
    .advance    (fire),
    .right      (middle_rd),
    .upper_in   (upper_rd),
    .lower      (sample),
    .center     (center),
    .center_max (center_max)
  );

  logic peak_hit;
  logic summary;

  // only interior cells with a full neighborhood are tested
  assign peak_hit = fire && (r_q >= RW'(2)) && (c_q != '0) && !last_col && center_max;
  assign summary  = fire && last_col && last_row;

  // ---------------------------------------------------------------------
  // Running maximum, seeded by the corner sample of each grid
  // ---------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] best_value;
  logic [RW-1:0]                 best_row;
  logic [CW-1:0]                 best_column;

  always_ff @(posedge clk) begin
    if (rst) begin
      best_value  <= '0;
      best_row    <= '0;
      best_column <= '0;
    end else if (fire && (r_q == '0) && (c_q == '0)) begin
      best_value  <= sample;
      best_row    <= '0;
      best_column <= '0;
    end else if (peak_hit && (center > best_value)) begin
      best_value  <= center;
      best_row    <= r_q - RW'(1);
      best_column <= c_q;
    end
  end

  // ---------------------------------------------------------------------
  // Result: a peak report or the end-of-grid summary, never both
  // ---------------------------------------------------------------------
  logic    res_valid;
  report_t res;

  assign res_valid = peak_hit || summary;

  always_comb begin
    if (summary) begin
      res.kind   = glpd_pkg::REPORT_SUMMARY;
      res.value  = best_value;
      res.row    = glpd_pkg::IDX_BITS'(best_row);
      res.column = glpd_pkg::IDX_BITS'(best_column);
      res.done   = 1'b1;
    end else begin
      res.kind   = glpd_pkg::REPORT_PEAK;
      res.value  = center;
      res.row    = glpd_pkg::IDX_BITS'(r_q - RW'(1));
      res.column = glpd_pkg::IDX_BITS'(c_q);
      res.done   = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Output register plus skid slot; input stalls only after a config write or while the skid is full
  // ---------------------------------------------------------------------
  logic    main_valid;
  logic    skid_valid;
  report_t main_q;
  report_t skid_q;
  logic    pop;

  assign pop      = main_valid && out_ready;
  assign in_ready = !skid_valid && !cfg_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // no new result can arrive while the skid is full
      if (pop) begin
        main_q     <= skid_q;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!main_valid || pop) begin
        main_q     <= res;
        main_valid <= 1'b1;
      end else begin
        skid_q     <= res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  assign out_valid   = main_valid;
  assign report_kind = main_q.kind;
  assign peak_value  = main_q.value;
  assign peak_row    = main_q.row;
  assign peak_column = main_q.column;
  assign frame_done  = main_q.done;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid slot full while output register empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(main_valid && !out_ready))
    else $error("skid slot filled without an output stall");

  a_peak_not_last_col: assert property (@(posedge clk) disable iff (rst)
    peak_hit |-> !summary)
    else $error("peak and summary in the same transaction");

  a_grid_wrap: assert property (@(posedge clk) disable iff (rst)
    summary |=> (c_q == '0) && (r_q == '0))
    else $error("counters did not wrap after the last sample of a grid");

  a_cfg_holdoff: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !fire)
    else $error("sample taken before prefetch was redone after a config write");

endmodule : grid_local_peak_detector

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for grid_local_peak_detector: valid/ready stimulus with random idling.
// Holds a peak scoreboard class that predicts peak and summary reports per accepted sample.
// Depends on glpd_pkg and the grid_local_peak_detector top level.
`timescale 1ns / 1ps

module tb_top;

  localparam int GRID_MAX       = 1024;  // largest grid side the block supports
  localparam int SETTLE_CYCLES  = 4;     // idle wait after the last expected report
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transaction before giving up
  localparam int RANDOM_ITEMS   = 800;
  localparam int CALM_ITEMS     = 650;   // past this count, stop idling

  // Report fields as the block presents them
  typedef struct packed {
    logic        kind;
    logic [15:0] value;
    logic [9:0]  row;
    logic [9:0]  column;
    logic        done;
  } grid_report_t;

  // How a grid gets filled
  typedef enum int {FILL_WIDE, FILL_NARROW, FILL_EXTREME, FILL_WRAP} fill_mode_t;

  // Tracks the grid walk, the line stores and the running maximum, and queues the
  // reports that each accepted sample must produce.
  class peak_scoreboard;
    logic signed [15:0] upper_row [GRID_MAX];
    logic signed [15:0] middle_row [GRID_MAX];
    logic signed [15:0] left_value;
    logic signed [15:0] best_value;
    logic [9:0]         best_row;
    logic [9:0]         best_column;
    int unsigned        row_pos;
    int unsigned        column_pos;
    logic [glpd_pkg::SIZE_BITS-1:0] columns_reg;
    logic [glpd_pkg::SIZE_BITS-1:0] rows_reg;
    grid_report_t       pending_reports [$];
    int                 errors;

    function new();
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      left_value  = '0;
      best_value  = '0;
      best_row    = '0;
      best_column = '0;
      row_pos     = 0;
      column_pos  = 0;
      columns_reg = glpd_pkg::GRID_COLUMNS_RESET;
      rows_reg    = glpd_pkg::GRID_ROWS_RESET;
      errors      = 0;
    endfunction

    // Register values below the minimum act as the minimum, above the maximum as the maximum
    static function int unsigned clamp_size(logic [glpd_pkg::SIZE_BITS-1:0] v);
      if (v < glpd_pkg::MIN_SIZE) return glpd_pkg::MIN_SIZE;
      if (v > GRID_MAX) return GRID_MAX;
      return v;
    endfunction

    function void set_size(logic [glpd_pkg::CFG_INDEX_BITS-1:0] index,
                           logic [glpd_pkg::SIZE_BITS-1:0] v);
      if (index == glpd_pkg::CFG_GRID_COLUMNS) columns_reg = v;
      else if (index == glpd_pkg::CFG_GRID_ROWS) rows_reg = v;
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function void note_sample(logic signed [15:0] s);
      int unsigned  cols;
      int unsigned  rows;
      int unsigned  c;
      int unsigned  r;
      logic signed [15:0] center;
      logic signed [15:0] up;
      logic signed [15:0] right;
      grid_report_t rep;
      cols = clamp_size(columns_reg);
      rows = clamp_size(rows_reg);
      c = column_pos;
      r = row_pos;
      if (c >= GRID_MAX) c = GRID_MAX - 1;
      // The corner sample seeds the running maximum
      if (r == 0 && c == 0) begin
        best_value  = s;
        best_row    = '0;
        best_column = '0;
      end
      center = middle_row[c];
      if (r >= 2 && c >= 1 && c + 1 < cols) begin
        up    = upper_row[c];
        right = middle_row[c + 1];
        if (center > left_value && center > right && center > up && center > s) begin
          rep.kind   = glpd_pkg::REPORT_PEAK;
          rep.value  = center;
          rep.row    = 10'(r - 1);
          rep.column = 10'(c);
          rep.done   = 1'b0;
          pending_reports.push_back(rep);
          if (center > best_value) begin
            best_value  = center;
            best_row    = 10'(r - 1);
            best_column = 10'(c);
          end
        end
      end
      left_value    = center;
      upper_row[c]  = center;
      middle_row[c] = s;
      if (c + 1 >= cols) begin
        column_pos = 0;
        if (r + 1 >= rows) begin
          row_pos    = 0;
          rep.kind   = glpd_pkg::REPORT_SUMMARY;
          rep.value  = best_value;
          rep.row    = best_row;
          rep.column = best_column;
          rep.done   = 1'b1;
          pending_reports.push_back(rep);
        end else begin
          row_pos = r + 1;
        end
      end else begin
        column_pos = c + 1;
      end
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (got !== want) begin
        $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_report(logic kind, logic signed [15:0] value, logic [9:0] row,
                               logic [9:0] column, logic done);
      grid_report_t want;
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected report: expected none, actual kind %0d value %0d at (%0d,%0d)",
                 $time, kind, value, row, column);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("report_kind", want.kind, kind);
      compare_field("peak_value", $signed(want.value), value);
      compare_field("peak_row", want.row, row);
      compare_field("peak_column", want.column, column);
      compare_field("frame_done", want.done, done);
    endfunction

    function void flag_leftovers();
      if (pending_reports.size() != 0) begin
        $display("%0t missing reports: expected %0d more, actual 0",
                 $time, pending_reports.size());
        errors++;
      end
    endfunction
  endclass

  // Drive every input to a known level from time zero
  logic                                 clk       = 1'b0;
  logic                                 rst       = 1'b1;
  logic                                 cfg_we    = 1'b0;
  logic [glpd_pkg::CFG_INDEX_BITS-1:0]  cfg_index = glpd_pkg::CFG_GRID_COLUMNS;
  logic [glpd_pkg::SIZE_BITS-1:0]       cfg_data  = '0;
  logic                                 in_valid  = 1'b0;
  logic                                 in_ready;
  logic signed [15:0]                   sample    = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic                                 report_kind;
  logic signed [15:0]                   peak_value;
  logic [glpd_pkg::IDX_BITS-1:0]        peak_row;
  logic [glpd_pkg::IDX_BITS-1:0]        peak_column;
  logic                                 frame_done;

  peak_scoreboard sb = new();

  // Idling knobs: percent chance of a gap before each sample (input) or of a stall starting (output)
  bit calm      = 1'b0;
  int gap_pct   = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  grid_local_peak_detector uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .report_kind (report_kind),
    .peak_value  (peak_value),
    .peak_row    (peak_row),
    .peak_column (peak_column),
    .frame_done  (frame_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: start stall bursts of random length, never once the run turns calm
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 13);
    end
    out_ready <= (stall_left == 0);
  end

  // Monitor: check accepted reports, then feed accepted samples to the predictor.
  // A report never comes from a sample accepted at the same edge, so order here is free.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_report(report_kind, peak_value, peak_row, peak_column, frame_done);
      if (in_valid && in_ready)
        sb.note_sample(sample);
    end
  end

  // Watchdog: give up once nothing has moved for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [15:0] next_sample(fill_mode_t mode);
    logic [15:0] v;
    case (mode)
      FILL_NARROW: begin
        // tiny range: plenty of ties against neighbors and the maximum
        v = 16'($urandom_range(0, 4)) - 16'd2;
      end
      FILL_EXTREME: begin
        case ($urandom_range(0, 4))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'hffff;
          3: v = 16'h0000;
          default: v = 16'($urandom);
        endcase
      end
      FILL_WRAP: begin
        // values either side of the two's complement wrap point
        if ($urandom_range(0, 1) == 1) v = 16'h7fff - 16'($urandom_range(0, 2));
        else v = 16'h8000 + 16'($urandom_range(0, 2));
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // Offer one sample and hold it until the transaction completes
  task automatic push_sample(input logic [15:0] v);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid, wait for every expected report, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both size registers on back-to-back cycles, holding the write enable
  task automatic write_sizes(input logic [glpd_pkg::SIZE_BITS-1:0] cols,
                             input logic [glpd_pkg::SIZE_BITS-1:0] rows);
    cfg_we    <= 1'b1;
    cfg_index <= glpd_pkg::CFG_GRID_COLUMNS;
    cfg_data  <= cols;
    @(posedge clk);
    sb.set_size(glpd_pkg::CFG_GRID_COLUMNS, cols);
    cfg_index <= glpd_pkg::CFG_GRID_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    sb.set_size(glpd_pkg::CFG_GRID_ROWS, rows);
    cfg_we <= 1'b0;
  endtask

  // Reconfigure while idle, then stream whole grids
  task automatic run_grids(input logic [glpd_pkg::SIZE_BITS-1:0] cols,
                           input logic [glpd_pkg::SIZE_BITS-1:0] rows,
                           input int grids, input fill_mode_t mode, output int sent);
    drain();
    write_sizes(cols, rows);
    sent = peak_scoreboard::clamp_size(cols) * peak_scoreboard::clamp_size(rows) * grids;
    repeat (sent) push_sample(next_sample(mode));
  endtask

  // Each directed grid is 3x3 in raster order
  task automatic push_grid3(input logic [15:0] g [9]);
    foreach (g[i]) push_sample(g[i]);
  endtask

  initial begin
    int sent;
    int random_items;
    logic [glpd_pkg::SIZE_BITS-1:0] cols;
    logic [glpd_pkg::SIZE_BITS-1:0] rows;
    logic [15:0] grid_a [9];
    logic [15:0] grid_b [9];
    logic [15:0] grid_c [9];

    // Peak at the max value beats a negative corner
    grid_a = '{16'hfffb, 16'd1, 16'd2,
               16'd3, 16'h7fff, 16'h8000,
               16'd0, 16'hffff, 16'd7};
    // Corner at the max value outlives a smaller peak
    grid_b = '{16'h7fff, 16'h8000, 16'd0,
               16'h8000, 16'd100, 16'h8000,
               16'd0, 16'h8000, 16'd0};
    // Center ties its upper neighbor: no peak, summary keeps the min-value corner
    grid_c = '{16'h8000, 16'd5, 16'd0,
               16'd1, 16'd5, 16'd4,
               16'd2, 16'd3, 16'h8000};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // One grid at the reset sizes, no idling
    repeat (int'(glpd_pkg::GRID_COLUMNS_RESET) * int'(glpd_pkg::GRID_ROWS_RESET))
      push_sample(next_sample(FILL_WIDE));

    // Directed grids; sizes below the minimum act as 3x3
    drain();
    write_sizes(11'd0, 11'd2);
    push_grid3(grid_a);
    push_grid3(grid_b);
    push_grid3(grid_c);

    // Shrink mid-grid: stop at row 5, column 8 of a 12x10 grid, then drop to 5x4.
    // Both counts now sit past the new last column and row, so the next sample ends the grid.
    gap_pct   = 20;
    stall_pct = 20;
    run_grids(11'd12, 11'd10, 0, FILL_WIDE, sent);
    repeat (5 * 12 + 8) push_sample(next_sample(FILL_WIDE));
    drain();
    write_sizes(11'd5, 11'd4);
    push_sample(next_sample(FILL_WIDE));
    repeat (20) push_sample(next_sample(FILL_NARROW));

    // Random small grids; idling level changes per phase and stops near the end
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      calm = (random_items >= CALM_ITEMS);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 10;
        default: stall_pct = 35;
      endcase
      cols = 11'($urandom_range(0, 20));
      rows = 11'($urandom_range(0, 12));
      run_grids(cols, rows, $urandom_range(1, 2), fill_mode_t'($urandom_range(0, 3)), sent);
      random_items += sent;
    end

    drain();
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
